@@ src/kpg_pkg.sv @@
`default_nettype none

package kpg_pkg;

  localparam int LINE_W     = 8;
  localparam int CODE_W     = 8;
  localparam int TIME_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 3;
  localparam int GAP_MS_W   = 16;
  localparam int NS_MS_W    = 20;
  // 65535 ms in ns still fits 36 bits
  localparam int GAP_NS_W   = 36;

  localparam logic [NS_MS_W-1:0]  NS_PER_MS     = 20'd1000000;
  localparam logic [GAP_MS_W-1:0] MIN_GAP_RESET = 16'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP    = 3'd0,
    CFG_SLOTS_USED = 3'd1,
    CFG_MAP_ENTRY0 = 3'd2,
    CFG_MAP_ENTRY1 = 3'd3,
    CFG_MAP_ENTRY2 = 3'd4,
    CFG_MAP_ENTRY3 = 3'd5,
    CFG_MAP_ENTRY4 = 3'd6,
    CFG_MAP_ENTRY5 = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              rising;
    logic [TIME_W-1:0] time_ns;
  } kpg_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic fire;
  } back_status_t;

endpackage

`default_nettype wire

@@ src/kpg_chan_if.sv @@
`default_nettype none

interface kpg_in_if import kpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_number;
  logic              rising_edge;
  logic [TIME_W-1:0] time_ns;

  modport source (output valid, output line_number, output rising_edge, output time_ns,
                  input ready);
  modport sink   (input valid, input line_number, input rising_edge, input time_ns,
                  output ready);
endinterface

interface kpg_out_if import kpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic              key_value;

  modport source (output valid, output key_code, output key_value, input ready);
  modport sink   (input valid, input key_code, input key_value, output ready);
endinterface

`default_nettype wire

@@ src/kpg_cfg.sv @@
`default_nettype none

module kpg_cfg import kpg_pkg::*; #(
  parameter int MAP_SLOTS = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [COUNT_W-1:0]         slots_used_o,
  output logic [CFG_DATA_W-1:0]      map_entry_o [MAP_SLOTS],
  output logic [GAP_NS_W-1:0]        gap_ns_o
);

  logic                  we;
  logic [GAP_MS_W-1:0]   min_gap_q, min_gap_d;
  logic [COUNT_W-1:0]    slots_used_q, slots_used_d;
  logic [CFG_DATA_W-1:0] entry_q [MAP_SLOTS];
  logic [CFG_DATA_W-1:0] entry_d [MAP_SLOTS];
  logic [GAP_NS_W-1:0]   gap_ns_q;

  assign cfg_ready_o = 1'b1;
  assign we          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    min_gap_d    = min_gap_q;
    slots_used_d = slots_used_q;
    entry_d      = entry_q;
    if (we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_GAP:    min_gap_d    = cfg_data_i[GAP_MS_W-1:0];
        CFG_SLOTS_USED: slots_used_d = cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
      for (int i = 0; i < MAP_SLOTS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(int'(CFG_MAP_ENTRY0) + i)) begin
          entry_d[i] = cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q    <= MIN_GAP_RESET;
      slots_used_q <= '0;
      for (int i = 0; i < MAP_SLOTS; i++) begin
        entry_q[i] <= '0;
      end
      gap_ns_q     <= GAP_NS_W'(MIN_GAP_RESET) * GAP_NS_W'(NS_PER_MS);
    end else begin
      min_gap_q    <= min_gap_d;
      slots_used_q <= slots_used_d;
      entry_q      <= entry_d;
      // gap in ns is a registered copy of the ms register, scaled
      gap_ns_q     <= GAP_NS_W'(min_gap_q) * GAP_NS_W'(NS_PER_MS);
    end
  end

  assign slots_used_o = slots_used_q;
  assign map_entry_o  = entry_q;
  assign gap_ns_o     = gap_ns_q;

endmodule

`default_nettype wire

@@ src/kpg_front.sv @@
`default_nettype none

module kpg_front import kpg_pkg::*; #(
  parameter int MAP_SLOTS = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  kpg_in_if.sink                     evt,
  input  wire logic [COUNT_W-1:0]    slots_used_i,
  input  wire logic [CFG_DATA_W-1:0] map_entry_i [MAP_SLOTS],
  input  wire q_status_t             q_status_i,
  output logic                       push_o,
  output kpg_item_t                  push_item_o
);

  logic              hit;
  logic [CODE_W-1:0] code;
  logic              f_valid_q, f_valid_d;
  kpg_item_t         f_item_q;
  logic              accept;

  // lowest matching slot wins: scan high to low
  always_comb begin
    hit  = 1'b0;
    code = '0;
    for (int i = MAP_SLOTS - 1; i >= 0; i--) begin
      if (i < int'(slots_used_i) &&
          map_entry_i[i][CFG_DATA_W-1:CODE_W] == evt.line_number) begin
        hit  = 1'b1;
        code = map_entry_i[i][CODE_W-1:0];
      end
    end
  end

  assign push_o    = f_valid_q & ~q_status_i.full;
  assign evt.ready = ~f_valid_q | push_o;
  assign accept    = evt.valid & evt.ready;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      // drop unmapped lines here
      f_valid_d = hit;
    end else if (push_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      f_item_q.code    <= code;
      f_item_q.rising  <= evt.rising_edge;
      f_item_q.time_ns <= evt.time_ns;
    end
  end

  assign push_item_o = f_item_q;

endmodule

`default_nettype wire

@@ src/kpg_queue.sv @@
`default_nettype none

module kpg_queue import kpg_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire kpg_item_t push_item_i,
  input  wire logic      pop_i,
  output kpg_item_t      head_o,
  output q_status_t      status_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  kpg_item_t         slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    count_d = count_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ src/kpg_back.sv @@
`default_nettype none

module kpg_back import kpg_pkg::*; #(
  parameter int KEY_CODES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kpg_item_t           head_i,
  input  wire q_status_t           q_status_i,
  input  wire logic [GAP_NS_W-1:0] gap_ns_i,
  output logic                     pop_o,
  kpg_out_if.source                key,
  output back_status_t             status_o
);

  localparam int SLOT_W = $clog2(KEY_CODES);

  logic [TIME_W-1:0] mem_q [KEY_CODES];
  logic [KEY_CODES-1:0] vld_q;

  logic [SLOT_W-1:0] head_slot;
  logic              b_valid_q, b_valid_d;
  kpg_item_t         b_item_q;
  logic [SLOT_W-1:0] b_slot_q;
  logic [TIME_W-1:0] rd_data_q;
  logic              rd_vld_q;
  logic              fwd_q;
  logic [TIME_W-1:0] fwd_data_q;

  logic [TIME_W-1:0] last;
  logic [TIME_W-1:0] elapsed;
  logic              too_soon;
  logic              emit;
  logic              wr_en;
  logic              b_fire;
  logic              out_free;
  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] out_code_q;
  logic              out_value_q;

  // codes past the store share entry zero
  assign head_slot = (int'(head_i.code) < KEY_CODES) ? head_i.code[SLOT_W-1:0] : '0;

  assign last     = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);
  assign elapsed  = b_item_q.time_ns - last;
  // floor(elapsed / 1e6) < gap  <=>  elapsed < gap * 1e6
  assign too_soon = (last != '0) && (elapsed < TIME_W'(gap_ns_i));
  assign emit     = ~b_item_q.rising | ~too_soon;

  assign out_free = ~out_valid_q | key.ready;
  assign b_fire   = b_valid_q & (out_free | ~emit);
  assign wr_en    = b_fire & b_item_q.rising & ~too_soon;
  assign pop_o    = ~q_status_i.empty & (~b_valid_q | b_fire);

  always_comb begin
    b_valid_d = b_valid_q;
    if (pop_o) begin
      b_valid_d = 1'b1;
    end else if (b_fire) begin
      b_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (b_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (key.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
      if (wr_en) vld_q[b_slot_q] <= 1'b1;
      if (pop_o) begin
        rd_vld_q <= vld_q[head_slot];
        // bypass a write to the same key landing on this edge
        fwd_q    <= wr_en && (b_slot_q == head_slot);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[b_slot_q] <= b_item_q.time_ns;
    end
    if (pop_o) begin
      rd_data_q <= mem_q[head_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_item_q   <= head_i;
      b_slot_q   <= head_slot;
      fwd_data_q <= b_item_q.time_ns;
    end
    if (b_fire && emit) begin
      out_code_q  <= b_item_q.code;
      out_value_q <= b_item_q.rising;
    end
  end

  assign key.valid     = out_valid_q;
  assign key.key_code  = out_code_q;
  assign key.key_value = out_value_q;

  assign status_o.busy = b_valid_q;
  assign status_o.fire = b_fire;

endmodule

`default_nettype wire

@@ src/keypad_press_gap_filter_core.sv @@
// Channel   Dir  Handshake                  Word
// evt_i     in   evt_i.valid / evt_i.ready  line_number, rising_edge, time_ns
// key_o     out  key_o.valid / key_o.ready  key_code, key_value
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Sustains one event word per cycle while key_o is not stalled; an event passes
// through the front register, 4-entry queue, back stage and output register in turn.
// The back stage reads the press time as a word enters it and writes it as the word
// leaves, with a bypass for the same key on consecutive words.
// Reset is asynchronous; the press-time store is cleared through per-key valid
// bits, so no clearing pass is needed. cfg_ready_o is always high.
// An output stall fills the output register, back stage, queue and front
// register in turn before evt_i.ready drops.
`default_nettype none

module keypad_press_gap_filter_core import kpg_pkg::*; #(
  parameter int MAP_SLOTS = 6,
  parameter int KEY_CODES = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  kpg_in_if.sink                     evt_i,
  kpg_out_if.source                  key_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [COUNT_W-1:0]    slots_used;
  logic [CFG_DATA_W-1:0] map_entry [MAP_SLOTS];
  logic [GAP_NS_W-1:0]   gap_ns;
  logic                  q_push;
  logic                  q_pop;
  kpg_item_t             q_in;
  kpg_item_t             q_head;
  q_status_t             q_stat;
  back_status_t          b_stat;

  kpg_cfg #(
    .MAP_SLOTS (MAP_SLOTS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .slots_used_o (slots_used),
    .map_entry_o  (map_entry),
    .gap_ns_o     (gap_ns)
  );

  kpg_front #(
    .MAP_SLOTS (MAP_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt          (evt_i),
    .slots_used_i (slots_used),
    .map_entry_i  (map_entry),
    .q_status_i   (q_stat),
    .push_o       (q_push),
    .push_item_o  (q_in)
  );

  kpg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .status_o    (q_stat)
  );

  kpg_back #(
    .KEY_CODES (KEY_CODES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .q_status_i (q_stat),
    .gap_ns_i   (gap_ns),
    .pop_o      (q_pop),
    .key        (key_o),
    .status_o   (b_stat)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_stat.full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_stat.empty))
    else $error("queue read while empty");

  a_pop_loads_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> b_stat.busy)
    else $error("popped word lost before back stage");

  a_out_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(key_o.valid) |-> $past(b_stat.fire))
    else $error("result appeared without a back-stage word");

endmodule

`default_nettype wire

@@ dv/keypad_press_gap_filter_core_tb.sv @@
`timescale 1ns / 1ps

module keypad_press_gap_filter_core_tb;
  import kpg_pkg::*;

  localparam int           MAP_SLOTS        = 6;
  localparam int           KEY_CODES        = 256;
  localparam logic [63:0]  NS_PER_MS_WIDE   = 64'd1_000_000;
  localparam int           DRAIN_CYCLES     = 16;
  localparam int           HOLD_CYCLES      = 80;
  localparam int           QUIET_LIMIT      = 5000;
  localparam int           RAND_PHASES      = 12;
  localparam int           EVENTS_PER_PHASE = 155;
  localparam int           HOLD_PHASE       = 0;

  typedef enum logic {ROW_EVT, ROW_CFG} row_kind_e;
  typedef enum logic {CHK_NONE, CHK_KEY} check_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              value;
  } key_word_t;

  typedef struct {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [15:0]       data;
    logic [LINE_W-1:0] line;
    logic              rising;
    logic [TIME_W-1:0] t;
    check_e            chk;
    key_word_t         word;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  kpg_in_if  evt_if ();
  kpg_out_if key_if ();

  keypad_press_gap_filter_core #(
    .MAP_SLOTS(MAP_SLOTS),
    .KEY_CODES(KEY_CODES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_if),
    .key_o      (key_if),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Filter state mirrored by the testbench
  logic [GAP_MS_W-1:0] gap_ms_q;
  logic [COUNT_W-1:0]  slots_used_q;
  logic [15:0]         key_map_q [MAP_SLOTS];
  logic [TIME_W-1:0]   press_time_q [KEY_CODES];

  key_word_t pending_keys [$];
  plan_row_t directed_plan [$];
  int        mismatch_cnt = 0;
  bit        no_idle      = 1'b0;
  bit        hold_req     = 1'b0;
  int        quiet_cycles = 0;

  function automatic void clear_filter();
    gap_ms_q     = MIN_GAP_RESET;
    slots_used_q = '0;
    foreach (key_map_q[i]) key_map_q[i] = '0;
    foreach (press_time_q[i]) press_time_q[i] = '0;
  endfunction

  function automatic void apply_reg(input cfg_idx_e idx, input logic [15:0] data);
    case (idx)
      CFG_MIN_GAP:    gap_ms_q = data;
      CFG_SLOTS_USED: slots_used_q = data[COUNT_W-1:0];
      default:        key_map_q[idx - CFG_MAP_ENTRY0] = data;
    endcase
  endfunction

  // Map the line, then gate presses on the per-key gap; update the press store.
  function automatic bit predict_key(input logic [LINE_W-1:0] line, input logic rising,
                                     input logic [TIME_W-1:0] t, output key_word_t w);
    int              used;
    bit              hit;
    logic [TIME_W-1:0] elapsed_ms;
    used = (slots_used_q > MAP_SLOTS) ? MAP_SLOTS : int'(slots_used_q);
    hit  = 1'b0;
    w    = '{code: '0, value: rising};
    for (int i = 0; i < used; i++) begin
      if (!hit && key_map_q[i][15:8] == line) begin
        hit    = 1'b1;
        w.code = key_map_q[i][7:0];
      end
    end
    if (!hit) return 1'b0;
    if (rising) begin
      if (press_time_q[w.code] != '0) begin
        elapsed_ms = (t - press_time_q[w.code]) / NS_PER_MS_WIDE;
        if (elapsed_ms < gap_ms_q) return 1'b0;
      end
      press_time_q[w.code] = t;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void add_cfg(input cfg_idx_e idx, input logic [15:0] data);
    plan_row_t r;
    r      = '{kind: ROW_CFG, idx: idx, data: data, line: '0, rising: 1'b0, t: '0,
               chk: CHK_NONE, word: '0};
    directed_plan.push_back(r);
  endfunction

  function automatic void add_evt(input logic [LINE_W-1:0] line, input logic rising,
                                  input logic [TIME_W-1:0] t, input check_e chk,
                                  input logic [CODE_W-1:0] code);
    plan_row_t r;
    r = '{kind: ROW_EVT, idx: CFG_MIN_GAP, data: '0, line: line, rising: rising, t: t,
          chk: chk, word: '{code: code, value: rising}};
    directed_plan.push_back(r);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  // Offer one event word; typed rows override the predicted outcome.
  task automatic post_event(input logic [LINE_W-1:0] line, input logic rising,
                            input logic [TIME_W-1:0] t, input bit typed,
                            input check_e chk, input key_word_t typed_word);
    key_word_t w;
    bit        has;
    evt_if.valid       <= 1'b1;
    evt_if.line_number <= line;
    evt_if.rising_edge <= rising;
    evt_if.time_ns     <= t;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    has = predict_key(line, rising, t, w);
    if (typed) begin
      has = (chk == CHK_KEY);
      w   = typed_word;
    end
    if (has) pending_keys.push_back(w);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Hold input until every expected word is out, then let dropped words flush.
  task automatic settle_pipeline();
    evt_if.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    key_word_t expd;
    if (rst_ni && key_if.valid && key_if.ready) begin
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected word code=%0h value=%0b",
                                  key_if.key_code, key_if.key_value));
      end else begin
        expd = pending_keys.pop_front();
        if (key_if.key_code !== expd.code)
          report_mismatch($sformatf("key_code got %0h exp %0h", key_if.key_code, expd.code));
        if (key_if.key_value !== expd.value)
          report_mismatch($sformatf("key_value got %0b exp %0b (code %0h)",
                                    key_if.key_value, expd.value, expd.code));
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((evt_if.valid && evt_if.ready) || (key_if.valid && key_if.ready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold on request
  initial begin
    key_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        key_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        key_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        key_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    bit                in_cfg;
    plan_row_t         row;
    logic [15:0]       gap;
    logic [COUNT_W-1:0] count;
    logic [7:0]        e_line;
    logic [7:0]        e_code;
    logic [TIME_W-1:0] clock_ns;
    logic [TIME_W-1:0] t;
    logic [LINE_W-1:0] line;
    logic              rising;
    int unsigned       step_ms;
    int                r;

    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = CFG_MIN_GAP;
    cfg_data_i         = '0;
    evt_if.valid       = 1'b0;
    evt_if.line_number = '0;
    evt_if.rising_edge = 1'b0;
    evt_if.time_ns     = '0;
    clear_filter();

    // No map after reset: nothing comes out
    add_evt(8'h00, 1'b1, 64'd0, CHK_NONE, 8'h00);
    add_evt(8'hFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, CHK_NONE, 8'h00);
    add_cfg(CFG_MIN_GAP, 16'd150);
    add_cfg(CFG_MAP_ENTRY0, 16'h00FF);
    add_cfg(CFG_MAP_ENTRY1, 16'hFF00);
    add_cfg(CFG_MAP_ENTRY2, 16'h1234);
    add_cfg(CFG_MAP_ENTRY3, 16'h1256);   // same line as entry 2, never wins
    add_cfg(CFG_MAP_ENTRY4, 16'hA534);   // other line, same key as entry 2
    add_cfg(CFG_MAP_ENTRY5, 16'h5A80);
    add_cfg(CFG_SLOTS_USED, 16'd7);      // saturates to all six entries
    add_evt(8'h00, 1'b0, 64'd5, CHK_KEY, 8'hFF);
    // press at time zero leaves the key looking never pressed
    add_evt(8'hFF, 1'b1, 64'd0, CHK_KEY, 8'h00);
    add_evt(8'hFF, 1'b1, 64'd1, CHK_KEY, 8'h00);
    add_evt(8'h12, 1'b1, 64'd1_000_000_000, CHK_KEY, 8'h34);
    add_evt(8'h12, 1'b1, 64'd1_149_999_999, CHK_NONE, 8'h34);
    add_evt(8'hA5, 1'b1, 64'd1_150_000_000, CHK_KEY, 8'h34);
    add_evt(8'h12, 1'b0, 64'd1_150_000_000, CHK_KEY, 8'h34);
    add_evt(8'h5A, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, CHK_KEY, 8'h80);
    // time runs backwards: wrapped difference is a few ns
    add_evt(8'h5A, 1'b1, 64'd10, CHK_NONE, 8'h80);
    add_evt(8'h77, 1'b1, 64'd2_000_000_000, CHK_NONE, 8'h00);
    add_cfg(CFG_MIN_GAP, 16'd0);
    add_evt(8'h5A, 1'b1, 64'd20, CHK_KEY, 8'h80);
    add_cfg(CFG_MIN_GAP, 16'hFFFF);
    add_evt(8'h12, 1'b1, 64'd66_685_000_000, CHK_KEY, 8'h34);
    add_evt(8'hA5, 1'b1, 64'd132_219_999_999, CHK_NONE, 8'h34);
    add_cfg(CFG_SLOTS_USED, 16'd0);
    add_evt(8'h00, 1'b0, 64'd3, CHK_NONE, 8'h00);
    add_cfg(CFG_SLOTS_USED, 16'd1);
    add_evt(8'h12, 1'b0, 64'd4, CHK_NONE, 8'h00);
    add_evt(8'h00, 1'b1, 64'd7, CHK_KEY, 8'hFF);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_cfg = 1'b0;
    foreach (directed_plan[n]) begin
      row = directed_plan[n];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) settle_pipeline();
        in_cfg = 1'b1;
        write_reg(row.idx, row.data);
      end else begin
        if (in_cfg) cfg_valid_i <= 1'b0;
        in_cfg = 1'b0;
        post_event(row.line, row.rising, row.t, 1'b1, row.chk, row.word);
      end
    end

    clock_ns = {$urandom, $urandom};
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_pipeline();
      if (p == RAND_PHASES - 1) no_idle = 1'b1;
      case (p % 5)
        0:       gap = 16'd0;
        1:       gap = 16'hFFFF;
        2:       gap = 16'($urandom_range(1, 40));
        3:       gap = 16'($urandom_range(100, 400));
        default: gap = 16'($urandom);
      endcase
      if (p == 3)      count = 3'd7;
      else if (p == 6) count = 3'($urandom_range(0, 2));
      else             count = 3'($urandom_range(3, 7));
      write_reg(CFG_MIN_GAP, gap);
      for (int e = 0; e < MAP_SLOTS; e++) begin
        e_line = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        e_code = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        write_reg(cfg_idx_e'(CFG_MAP_ENTRY0 + e), {e_line, e_code});
      end
      write_reg(CFG_SLOTS_USED, {13'($urandom), count});
      cfg_valid_i <= 1'b0;
      // long output stall while words keep coming
      if (p == HOLD_PHASE) hold_req = 1'b1;

      repeat (EVENTS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          t = {$urandom, $urandom};
        end else if (r < 6) begin
          t = '0;
        end else if (r < 10) begin
          t = clock_ns - TIME_W'($urandom_range(0, 5_000_000));
        end else begin
          // land near the gap boundary often
          if (r < 35) step_ms = (gap == 0) ? 0 : gap - 1 + $urandom_range(0, 1);
          else        step_ms = $urandom_range(0, 2 * gap + 2);
          clock_ns += TIME_W'(step_ms) * NS_PER_MS_WIDE +
                      TIME_W'($urandom_range(0, 999_999));
          t = clock_ns;
        end
        if ($urandom_range(0, 99) < 85) line = key_map_q[$urandom_range(0, MAP_SLOTS - 1)][15:8];
        else                            line = 8'($urandom);
        rising = ($urandom_range(0, 9) < 6);
        post_event(line, rising, t, 1'b0, CHK_NONE, '0);
      end
    end

    settle_pipeline();
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
